/* rtl/cnvt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cnvt_pkg
// Shared constants, codes and types of the cosine nearest vector table.
// ----------------------------------------------------------------------------
package cnvt_pkg;

    localparam int CAPACITY = 1024;
    localparam int DIM      = 64;

    localparam int ELEM_W  = 16;
    localparam int TID_W   = 16;
    localparam int ID_W    = 11;
    localparam int SCORE_W = 16;

    localparam int ENT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int POS_W   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CIDX_W  = $clog2(DIM + 1);
    localparam int VADDR_W = (CAPACITY * DIM > 1) ? $clog2(CAPACITY * DIM) : 1;

    // Sums of squares of Q8.8 values over DIM positions.
    localparam int NRM_W    = 31 + $clog2(DIM);
    localparam int DOT_W    = NRM_W + 1;
    localparam int PRD_W    = 2 * NRM_W;
    localparam int REM_W    = PRD_W + 1;
    localparam int QUO_W    = 31;
    localparam int SQ_W     = 32;
    localparam int DIV_STEPS = QUO_W;
    localparam int SQ_STEPS  = SQ_W / 2;
    localparam int SC_CNT_W  = $clog2(NRM_W + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [1:0] CMD_INS = 2'd0;
    localparam logic [1:0] CMD_QRY = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic signed [SCORE_W-1:0] SCORE_ONE = 16'sd16384;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [ELEM_W-1:0] elem;
        logic                     last;
        logic [TID_W-1:0]         target;
        logic                     wr;     // position is inside the vector
        logic [POS_W-1:0]         pos;
        logic [CIDX_W-1:0]        cnt;    // components held after this one
    } t_item;

    typedef struct packed {
        logic                    start;
        logic signed [DOT_W-1:0] dot;
        logic [NRM_W-1:0]        nq;
        logic [NRM_W-1:0]        nd;
    } t_score_req;

    function automatic logic [VADDR_W-1:0] vaddr(input logic [CNT_W-1:0] e,
                                                 input logic [CIDX_W-1:0] p);
        return VADDR_W'(e * DIM + p);
    endfunction

endpackage
`default_nettype wire

/* rtl/cnvt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cnvt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cnvt_ram #(
    parameter int W = 16,
    parameter int D = 64
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire [W-1:0]                     i_wdata,
    input  wire [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                    o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* rtl/cnvt_score.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cnvt_score
// Sequential cosine score: shift-add products, restoring divide, bitwise
// square root, rounded to Q1.14.
// ----------------------------------------------------------------------------
module cnvt_score (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire cnvt_pkg::t_score_req        i_req,
    output logic                             o_done,
    output logic signed [cnvt_pkg::SCORE_W-1:0] o_score
);
    import cnvt_pkg::*;

    localparam logic [2:0] SC_IDLE = 3'd0;
    localparam logic [2:0] SC_MUL  = 3'd1;
    localparam logic [2:0] SC_DIV  = 3'd2;
    localparam logic [2:0] SC_SQRT = 3'd3;
    localparam logic [2:0] SC_DONE = 3'd4;

    logic [2:0]          r_state;
    logic [SC_CNT_W-1:0] r_cnt;
    logic                r_neg;
    logic [NRM_W-1:0]    r_mplr_a, r_mplr_b;
    logic [PRD_W-1:0]    r_mcand_a, r_mcand_b;
    logic [PRD_W-1:0]    r_d2, r_pp;
    logic [REM_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [SQ_W-1:0]     r_op, r_res, r_one;
    logic signed [SCORE_W-1:0] r_score;

    logic [PRD_W-1:0] n_d2, n_pp;
    logic [REM_W-1:0] rem_sh, n_rem;
    logic             ge;
    logic [QUO_W-1:0] n_quo;
    logic [SQ_W-1:0]  sq_t, n_op, n_res;
    logic [SQ_W-1:0]  s_mag;
    logic [DOT_W-1:0] dot_abs;

    always_comb begin
        dot_abs = i_req.dot[DOT_W-1] ? DOT_W'(-i_req.dot) : DOT_W'(i_req.dot);
        n_d2 = r_mplr_a[0] ? r_d2 + r_mcand_a : r_d2;
        n_pp = r_mplr_b[0] ? r_pp + r_mcand_b : r_pp;
        rem_sh = (r_cnt == '0) ? r_rem : {r_rem[REM_W-2:0], 1'b0};
        ge     = rem_sh >= REM_W'(r_pp);
        n_rem  = ge ? rem_sh - REM_W'(r_pp) : rem_sh;
        n_quo  = {r_quo[QUO_W-2:0], ge};
        sq_t   = r_res + r_one;
        if (r_op >= sq_t) begin
            n_op  = r_op - sq_t;
            n_res = (r_res >> 1) + r_one;
        end else begin
            n_op  = r_op;
            n_res = r_res >> 1;
        end
        s_mag = (n_res + SQ_W'(1)) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                SC_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.nq == '0 || i_req.nd == '0) begin
                            r_score <= '0;
                            r_state <= SC_DONE;
                        end else begin
                            r_neg     <= i_req.dot[DOT_W-1];
                            r_mplr_a  <= dot_abs[NRM_W-1:0];
                            r_mcand_a <= PRD_W'(dot_abs[NRM_W-1:0]);
                            r_mplr_b  <= i_req.nq;
                            r_mcand_b <= PRD_W'(i_req.nd);
                            r_d2      <= '0;
                            r_pp      <= '0;
                            r_cnt     <= '0;
                            r_state   <= SC_MUL;
                        end
                    end
                end
                SC_MUL: begin
                    r_d2      <= n_d2;
                    r_pp      <= n_pp;
                    r_mplr_a  <= r_mplr_a >> 1;
                    r_mplr_b  <= r_mplr_b >> 1;
                    r_mcand_a <= r_mcand_a << 1;
                    r_mcand_b <= r_mcand_b << 1;
                    r_cnt     <= r_cnt + 1'b1;
                    if (r_cnt == SC_CNT_W'(NRM_W - 1)) begin
                        r_rem   <= REM_W'(n_d2);
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= SC_DIV;
                    end
                end
                SC_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SC_CNT_W'(DIV_STEPS - 1)) begin
                        r_op    <= SQ_W'(n_quo);
                        r_res   <= '0;
                        r_one   <= SQ_W'(1) << (SQ_W - 2);
                        r_cnt   <= '0;
                        r_state <= SC_SQRT;
                    end
                end
                SC_SQRT: begin
                    r_op  <= n_op;
                    r_res <= n_res;
                    r_one <= r_one >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SC_CNT_W'(SQ_STEPS - 1)) begin
                        r_score <= r_neg ? -SCORE_W'(s_mag) : SCORE_W'(s_mag);
                        r_state <= SC_DONE;
                    end
                end
                SC_DONE: r_state <= SC_IDLE;
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == SC_DONE);
    assign o_score = r_score;
endmodule
`default_nettype wire

/* rtl/cnvt_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cnvt_front
// Accepts input transfers, tracks the component position and queues the
// classified items for the back end.
// ----------------------------------------------------------------------------
module cnvt_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire [1:0]                         i_cmd,
    input  wire [cnvt_pkg::ELEM_W-1:0]        i_elem,
    input  wire                               i_last,
    input  wire [cnvt_pkg::TID_W-1:0]         i_target,
    input  wire                               i_pop,
    output logic                              o_q_valid,
    output cnvt_pkg::t_item                   o_q_item
);
    import cnvt_pkg::*;

    t_item             r_q [QDEPTH];
    logic [QPTR_W:0]   r_wp, r_rp;
    logic [CIDX_W-1:0] r_ci;
    logic [CIDX_W-1:0] n_ci;
    logic              accept, push;
    t_item             item;

    assign o_ready   = (r_wp - r_rp) != (QPTR_W + 1)'(QDEPTH);
    assign o_q_valid = (r_wp != r_rp);
    assign o_q_item  = r_q[r_rp[QPTR_W-1:0]];
    assign accept    = i_valid && o_ready;
    assign push      = accept && (i_cmd != CMD_NOP);

    always_comb begin
        item.cmd    = i_cmd;
        item.elem   = i_elem;
        item.last   = i_last;
        item.target = i_target;
        item.wr     = r_ci < CIDX_W'(DIM);
        item.pos    = r_ci[POS_W-1:0];
        item.cnt    = item.wr ? r_ci + 1'b1 : r_ci;
        if (i_cmd == CMD_DEL || (i_cmd != CMD_NOP && i_last)) begin
            n_ci = '0;
        end else if (i_cmd != CMD_NOP) begin
            n_ci = item.cnt;
        end else begin
            n_ci = r_ci;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_ci <= '0;
        end else begin
            if (accept) begin
                r_ci <= n_ci;
            end
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp[QPTR_W-1:0]] <= item;
        end
    end
endmodule
`default_nettype wire

/* rtl/cnvt_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cnvt_back
// Executes queued items on the vector, id and query stores: stores inserts,
// shifts entries on delete, scans all entries on query, registers results.
// ----------------------------------------------------------------------------
module cnvt_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_q_valid,
    input  wire cnvt_pkg::t_item               i_q_item,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [1:0]                         o_status,
    output logic [cnvt_pkg::ID_W-1:0]          o_id,
    output logic signed [cnvt_pkg::SCORE_W-1:0] o_score
);
    import cnvt_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ZFILL   = 4'd1;
    localparam logic [3:0] S_INSID   = 4'd2;
    localparam logic [3:0] S_DRD     = 4'd3;
    localparam logic [3:0] S_DCMP    = 4'd4;
    localparam logic [3:0] S_SHID_RD = 4'd5;
    localparam logic [3:0] S_SHID_WR = 4'd6;
    localparam logic [3:0] S_SHV_RD  = 4'd7;
    localparam logic [3:0] S_SHV_WR  = 4'd8;
    localparam logic [3:0] S_SCAN    = 4'd9;
    localparam logic [3:0] S_SCORE   = 4'd10;
    localparam logic [3:0] S_IDRD    = 4'd11;
    localparam logic [3:0] S_IDWT    = 4'd12;
    localparam logic [3:0] S_RES     = 4'd13;

    logic [3:0]        r_state;
    logic [CNT_W-1:0]  r_count, r_i;
    logic [CIDX_W-1:0] r_p, r_qd;
    logic [TID_W-1:0]  r_target;
    logic [ENT_W-1:0]  r_best;
    logic signed [SCORE_W-1:0] r_best_score;
    logic              r_v1, r_v2, r_start;
    logic signed [31:0] r_pd_dot;
    logic [30:0]       r_pd_q, r_pd_d;
    logic signed [DOT_W-1:0] r_acc_dot;
    logic [NRM_W-1:0]  r_acc_nq, r_acc_nd;
    logic [1:0]        r_res_status;
    logic [ID_W-1:0]   r_res_id;
    logic signed [SCORE_W-1:0] r_res_score;
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [ID_W-1:0]   r_out_id;
    logic signed [SCORE_W-1:0] r_out_score;

    logic               vwe, qwe, iwe;
    logic [VADDR_W-1:0] vwaddr, vraddr;
    logic [ELEM_W-1:0]  vwdata, vrdata, qrdata;
    logic [POS_W-1:0]   qwaddr, qraddr;
    logic [ENT_W-1:0]   iwaddr, iraddr;
    logic [CNT_W-1:0]   iwdata, irdata;
    logic [CNT_W-1:0]   r_i1;
    logic               room;
    logic               sc_done;
    logic signed [SCORE_W-1:0] sc_score;
    logic signed [31:0] pd_dot, pd_q, pd_d;
    t_score_req         req;
    t_item              hd;

    assign hd   = i_q_item;
    assign room = r_count < CNT_W'(CAPACITY);
    assign r_i1 = r_i + 1'b1;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        vwe    = 1'b0;
        vwaddr = vaddr(r_count, r_p);
        vwdata = '0;
        vraddr = vaddr(r_i, r_p);
        qwe    = 1'b0;
        qwaddr = hd.pos;
        qraddr = r_p[POS_W-1:0];
        iwe    = 1'b0;
        iwaddr = r_i[ENT_W-1:0];
        iwdata = vrdata[CNT_W-1:0];
        iraddr = r_i[ENT_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && hd.wr) begin
                    vwe    = (hd.cmd == CMD_INS) && room;
                    vwaddr = vaddr(r_count, CIDX_W'(hd.pos));
                    vwdata = hd.elem;
                    qwe    = (hd.cmd == CMD_QRY);
                end
            end
            S_ZFILL: vwe = 1'b1;
            S_INSID: begin
                iwe    = 1'b1;
                iwaddr = r_count[ENT_W-1:0];
                iwdata = r_count + 1'b1;
            end
            S_SHID_RD: iraddr = r_i1[ENT_W-1:0];
            S_SHID_WR: begin
                iwe    = 1'b1;
                iwdata = irdata;
            end
            S_SHV_RD: vraddr = vaddr(r_i1, r_p);
            S_SHV_WR: begin
                vwe    = 1'b1;
                vwaddr = vaddr(r_i, r_p);
                vwdata = vrdata;
            end
            S_IDRD: iraddr = r_best;
            default: ;
        endcase
    end

    cnvt_ram #(.W(ELEM_W), .D(CAPACITY * DIM)) u_vram (
        .i_clk(i_clk), .i_we(vwe), .i_waddr(vwaddr), .i_wdata(vwdata),
        .i_raddr(vraddr), .o_rdata(vrdata)
    );
    cnvt_ram #(.W(ELEM_W), .D(DIM)) u_qram (
        .i_clk(i_clk), .i_we(qwe), .i_waddr(qwaddr), .i_wdata(hd.elem),
        .i_raddr(qraddr), .o_rdata(qrdata)
    );
    cnvt_ram #(.W(CNT_W), .D(CAPACITY)) u_iram (
        .i_clk(i_clk), .i_we(iwe), .i_waddr(iwaddr), .i_wdata(iwdata),
        .i_raddr(iraddr), .o_rdata(irdata)
    );

    assign req.start = r_start;
    assign req.dot   = r_acc_dot;
    assign req.nq    = r_acc_nq;
    assign req.nd    = r_acc_nd;

    cnvt_score u_score (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req),
        .o_done(sc_done), .o_score(sc_score)
    );

    assign pd_dot = $signed(qrdata) * $signed(vrdata);
    assign pd_q   = $signed(qrdata) * $signed(qrdata);
    assign pd_d   = $signed(vrdata) * $signed(vrdata);

    // Product stage of the scan.
    always_ff @(posedge i_clk) begin
        r_pd_dot <= pd_dot;
        r_pd_q   <= pd_q[30:0];
        r_pd_d   <= pd_d[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_start     <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_target    <= hd.target;
                        r_res_id    <= '0;
                        r_res_score <= '0;
                        r_i         <= '0;
                        r_p         <= '0;
                        case (hd.cmd)
                            CMD_INS: begin
                                if (hd.last) begin
                                    if (!room) begin
                                        r_res_status <= ST_FULL;
                                        r_state      <= S_RES;
                                    end else if (hd.cnt < CIDX_W'(DIM)) begin
                                        r_p     <= hd.cnt;
                                        r_state <= S_ZFILL;
                                    end else begin
                                        r_state <= S_INSID;
                                    end
                                end
                            end
                            CMD_QRY: begin
                                if (hd.last) begin
                                    if (r_count == '0) begin
                                        r_res_status <= ST_EMPTY;
                                        r_state      <= S_RES;
                                    end else begin
                                        r_qd      <= hd.cnt;
                                        r_acc_dot <= '0;
                                        r_acc_nq  <= '0;
                                        r_acc_nd  <= '0;
                                        r_state   <= S_SCAN;
                                    end
                                end
                            end
                            CMD_DEL: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_NOTFOUND;
                                    r_state      <= S_RES;
                                end else begin
                                    r_state <= S_DRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ZFILL: begin
                    r_p <= r_p + 1'b1;
                    if (r_p == CIDX_W'(DIM - 1)) begin
                        r_state <= S_INSID;
                    end
                end
                S_INSID: begin
                    r_count      <= r_count + 1'b1;
                    r_res_status <= ST_DONE;
                    r_res_id     <= ID_W'(r_count + 1'b1);
                    r_state      <= S_RES;
                end
                S_DRD: r_state <= S_DCMP;
                S_DCMP: begin
                    if (TID_W'(irdata) == r_target) begin
                        if (r_i1 < r_count) begin
                            r_p     <= '0;
                            r_state <= S_SHID_RD;
                        end else begin
                            r_count      <= r_count - 1'b1;
                            r_res_status <= ST_DONE;
                            r_res_id     <= r_target[ID_W-1:0];
                            r_state      <= S_RES;
                        end
                    end else if (r_i1 == r_count) begin
                        r_res_status <= ST_NOTFOUND;
                        r_state      <= S_RES;
                    end else begin
                        r_i     <= r_i1;
                        r_state <= S_DRD;
                    end
                end
                S_SHID_RD: r_state <= S_SHID_WR;
                S_SHID_WR: begin
                    r_p     <= '0;
                    r_state <= S_SHV_RD;
                end
                S_SHV_RD: r_state <= S_SHV_WR;
                S_SHV_WR: begin
                    r_p     <= r_p + 1'b1;
                    r_state <= S_SHV_RD;
                    if (r_p == CIDX_W'(DIM - 1)) begin
                        r_i <= r_i1;
                        if ((CNT_W + 1)'(r_i) + 2'd2 < (CNT_W + 1)'(r_count)) begin
                            r_state <= S_SHID_RD;
                        end else begin
                            r_count      <= r_count - 1'b1;
                            r_res_status <= ST_DONE;
                            r_res_id     <= r_target[ID_W-1:0];
                            r_state      <= S_RES;
                        end
                    end
                end
                S_SCAN: begin
                    // Read, multiply and accumulate overlap one position apart.
                    r_v1 <= r_p < r_qd;
                    r_v2 <= r_v1;
                    if (r_p < r_qd) begin
                        r_p <= r_p + 1'b1;
                    end
                    if (r_v2) begin
                        r_acc_dot <= r_acc_dot + DOT_W'(r_pd_dot);
                        r_acc_nq  <= r_acc_nq + NRM_W'(r_pd_q);
                        r_acc_nd  <= r_acc_nd + NRM_W'(r_pd_d);
                    end
                    if (r_p == r_qd && !r_v1 && !r_v2) begin
                        r_start <= 1'b1;
                        r_state <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    if (sc_done) begin
                        if (r_i == '0 || sc_score > r_best_score) begin
                            r_best_score <= sc_score;
                            r_best       <= r_i[ENT_W-1:0];
                        end
                        r_i <= r_i1;
                        if (r_i1 == r_count) begin
                            r_state <= S_IDRD;
                        end else begin
                            r_p       <= '0;
                            r_acc_dot <= '0;
                            r_acc_nq  <= '0;
                            r_acc_nd  <= '0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_IDRD: r_state <= S_IDWT;
                S_IDWT: begin
                    r_res_status <= ST_DONE;
                    r_res_id     <= ID_W'(irdata);
                    r_res_score  <= r_best_score;
                    r_state      <= S_RES;
                end
                S_RES: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RES && (!r_out_valid || i_ready)) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_score  <= r_res_score;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_id     = r_out_id;
    assign o_score  = r_out_score;
endmodule
`default_nettype wire

/* rtl/cosine_nearest_vector_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_nearest_vector_table
// Table of id-tagged Q8.8 vectors with insert, delete and nearest-by-cosine
// query.
//
//   channel   dir  tdata                                tuser    tlast
//   s_axis    in   [15:0] element, [31:16] target_id    cmd      last
//   m_axis    out  [10:0] entry_id, [26:11] score      status   -
//
// A final insert zero-fills the positions it did not give and then stores its
// id. A query reads, multiplies and accumulates each entry, then scores it in
// the serial score unit (multiply, divide, square root), which gives a score
// of zero when a norm is zero, and then fetches the winning id. A delete
// compares ids one entry at a time and moves each later entry down by one
// slot. A four-entry queue lets components arrive while a scan runs. Reset is
// synchronous; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module cosine_nearest_vector_table (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [31:0]  s_axis_tdata,   // element, target_id
    input  wire [1:0]   s_axis_tuser,   // cmd
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // entry_id, score, zero pad
    output logic [1:0]  m_axis_tuser    // status
);
    import cnvt_pkg::*;

    logic            q_valid, q_pop;
    t_item           q_item;
    logic [ID_W-1:0] res_id;
    logic signed [SCORE_W-1:0] res_score;

    cnvt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tuser), .i_elem(s_axis_tdata[15:0]),
        .i_last(s_axis_tlast), .i_target(s_axis_tdata[31:16]),
        .i_pop(q_pop), .o_q_valid(q_valid), .o_q_item(q_item)
    );

    cnvt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(m_axis_tuser), .o_id(res_id), .o_score(res_score)
    );

    assign m_axis_tdata = {5'd0, res_score, res_id};

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_full_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> (m_axis_tdata == 32'd0))
        else $error("full status with nonzero id or score");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[26:11]) <= SCORE_ONE &&
                           $signed(m_axis_tdata[26:11]) >= -SCORE_ONE))
        else $error("score outside unit range");
endmodule
`default_nettype wire

/* tb/sv/tb_cosine_nearest_vector_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cosine_nearest_vector_table
// Self-checking bench for the cosine nearest vector table. A directed list
// covers empty and missing-id cases, extreme components, short and overlong
// vectors, mixed commands and deletes that cut a vector short. A random mix
// of inserts, queries and deletes follows, then a final phase fills the table
// to capacity and hits the full cases. Results are checked against the list
// or a local model, with random idle bursts on both streams before the fill.
// ----------------------------------------------------------------------------
module tb_cosine_nearest_vector_table;
    import cnvt_pkg::*;

    typedef struct {
        logic [1:0]         status;
        logic [ID_W-1:0]    entry_id;
        logic signed [15:0] score;
    } result_t;

    typedef struct {
        logic [1:0]         cmd;
        logic [15:0]        elem;
        int                 reps;
        logic               last;
        logic [15:0]        target;
        bit                 typed;
        logic [1:0]         status;
        logic [ID_W-1:0]    entry_id;
        logic signed [15:0] score;
    } plan_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata = '0;    // [15:0] element, [31:16] target_id
    logic [1:0]  s_axis_tuser = CMD_NOP; // cmd
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;         // [10:0] entry_id, [26:11] score
    wire  [1:0]  m_axis_tuser;         // status

    cosine_nearest_vector_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Local copy of the table contents.
    shortint         vec_mem [CAPACITY][DIM];
    logic [ID_W-1:0] id_mem  [CAPACITY];
    shortint         qry_buf [DIM];
    int              entries;
    int              comp_pos;

    result_t results_due[$];
    int      errors = 0;
    int      checked = 0;
    int      items_sent = 0;
    int      n_full = 0, n_empty = 0, n_miss = 0;
    bit      bursts_on = 1'b1;

    function automatic int cosine_q14(longint dot, longint nq, longint nd);
        logic [127:0] rhs, prod;
        logic [63:0]  mag, t;
        int           lo, hi, mid;
        if (nq == 0 || nd == 0)
            return 0;
        mag = (dot < 0) ? -dot : dot;
        rhs = (128'(mag) * 128'(mag)) << 30;
        prod = 128'(nq) * 128'(nd);
        lo = 0;
        hi = 16384;
        // Largest s with (2s-1)^2 * nq * nd <= 2^30 * dot^2, i.e. the rounded score.
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 64'(2 * mid - 1);
            if (prod * 128'(t * t) <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (dot < 0) ? -lo : lo;
    endfunction

    function automatic void table_apply(input logic [1:0] cmd, input logic [15:0] elem,
                                        input logic last, input logic [15:0] target,
                                        output bit has, output result_t r);
        longint dot, nq, nd, q, d;
        int     best, best_sc, sc;
        has = 1'b0;
        r = '{status: ST_DONE, entry_id: '0, score: '0};
        if (cmd == CMD_NOP)
            return;
        if (cmd == CMD_DEL) begin
            has = 1'b1;
            r.status = ST_NOTFOUND;
            for (int i = 0; i < entries; i++) begin
                if (32'(id_mem[i]) == 32'(target)) begin
                    for (int j = i; j + 1 < entries; j++) begin
                        id_mem[j] = id_mem[j+1];
                        vec_mem[j] = vec_mem[j+1];
                    end
                    entries--;
                    r.status = ST_DONE;
                    r.entry_id = target[ID_W-1:0];
                    break;
                end
            end
            comp_pos = 0;
            return;
        end
        if (comp_pos < DIM) begin
            if (cmd == CMD_QRY)
                qry_buf[comp_pos] = elem;
            else if (entries < CAPACITY)
                vec_mem[entries][comp_pos] = elem;
            comp_pos++;
        end
        if (!last)
            return;
        has = 1'b1;
        if (cmd == CMD_INS) begin
            if (entries >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                for (int j = comp_pos; j < DIM; j++)
                    vec_mem[entries][j] = 0;
                id_mem[entries] = ID_W'(entries + 1);
                r.entry_id = ID_W'(entries + 1);
                entries++;
            end
        end else if (entries == 0) begin
            r.status = ST_EMPTY;
        end else begin
            best = 0;
            best_sc = 0;
            for (int i = 0; i < entries; i++) begin
                dot = 0; nq = 0; nd = 0;
                for (int j = 0; j < comp_pos; j++) begin
                    q = qry_buf[j];
                    d = vec_mem[i][j];
                    dot += q * d;
                    nq += q * q;
                    nd += d * d;
                end
                sc = cosine_q14(dot, nq, nd);
                if (i == 0 || sc > best_sc) begin
                    best_sc = sc;
                    best = i;
                end
            end
            r.entry_id = id_mem[best];
            r.score = 16'(best_sc);
        end
        comp_pos = 0;
    endfunction

    task automatic send(input logic [1:0] cmd, input logic [15:0] elem, input logic last,
                        input logic [15:0] target, input bit typed, input result_t want);
        bit      has;
        result_t r;
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {target, elem};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        table_apply(cmd, elem, last, target, has, r);
        if (cmd != CMD_NOP)
            items_sent++;
        if (has) begin
            if (typed)
                results_due.push_back(want);
            else
                results_due.push_back(r);
        end
    endtask

    function automatic logic [15:0] rand_elem(int flavor);
        case (flavor)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    task automatic send_vector(input logic [1:0] cmd, input int len, input logic last_end);
        result_t none;
        int      flavor;
        none = '{status: ST_DONE, entry_id: '0, score: '0};
        flavor = $urandom_range(0, 9);
        for (int k = 0; k < len; k++)
            send(cmd, rand_elem((flavor < 3) ? $urandom_range(0, 9) : flavor),
                 (k == len - 1) ? last_end : 1'b0, 16'($urandom), 1'b0, none);
    endtask

    function automatic int rand_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
    endfunction

    // Result side: stall bursts, and the comparison against the oldest expectation.
    initial begin
        forever begin
            if (bursts_on && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, actual status %0d id %0d score %0d",
                         $time, m_axis_tuser, m_axis_tdata[10:0],
                         $signed(m_axis_tdata[26:11]));
            end else begin
                want = results_due.pop_front();
                checked++;
                if (want.status == ST_FULL) n_full++;
                if (want.status == ST_EMPTY) n_empty++;
                if (want.status == ST_NOTFOUND) n_miss++;
                if (m_axis_tuser !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                end
                if (m_axis_tdata[10:0] !== want.entry_id) begin
                    errors++;
                    $display("%0t: entry_id expected %0d actual %0d",
                             $time, want.entry_id, m_axis_tdata[10:0]);
                end
                if (m_axis_tdata[26:11] !== want.score) begin
                    errors++;
                    $display("%0t: score expected %0d actual %0d",
                             $time, want.score, $signed(m_axis_tdata[26:11]));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    plan_row_t plan [17] = '{
        '{CMD_DEL, 16'h0000,  1, 1'b1, 16'd5,    1'b1, ST_NOTFOUND, 11'd0, 16'sd0},
        '{CMD_QRY, 16'h7fff, 70, 1'b1, 16'd0,    1'b1, ST_EMPTY,    11'd0, 16'sd0},
        '{CMD_INS, 16'h0100,  1, 1'b1, 16'd0,    1'b1, ST_DONE,     11'd1, 16'sd0},
        '{CMD_INS, 16'h8000, 64, 1'b1, 16'd0,    1'b1, ST_DONE,     11'd2, 16'sd0},
        '{CMD_INS, 16'h7fff, 80, 1'b1, 16'd0,    1'b1, ST_DONE,     11'd3, 16'sd0},
        '{CMD_INS, 16'h0000,  3, 1'b1, 16'd0,    1'b1, ST_DONE,     11'd4, 16'sd0},
        '{CMD_QRY, 16'h0100,  1, 1'b1, 16'd0,    1'b0, ST_DONE,     11'd0, 16'sd0},
        '{CMD_QRY, 16'h8000, 64, 1'b1, 16'd0,    1'b0, ST_DONE,     11'd0, 16'sd0},
        '{CMD_QRY, 16'h0000,  5, 1'b1, 16'd0,    1'b1, ST_DONE,     11'd1, 16'sd0},
        '{CMD_NOP, 16'h1234,  1, 1'b1, 16'hffff, 1'b0, ST_DONE,     11'd0, 16'sd0},
        // A delete with last low drops the partial insert and still acts.
        '{CMD_INS, 16'h0005,  2, 1'b0, 16'd0,    1'b0, ST_DONE,     11'd0, 16'sd0},
        '{CMD_DEL, 16'h0000,  1, 1'b0, 16'd3,    1'b1, ST_DONE,     11'd3, 16'sd0},
        '{CMD_DEL, 16'h0000,  1, 1'b1, 16'hffff, 1'b1, ST_NOTFOUND, 11'd0, 16'sd0},
        // Insert components followed by a query component that ends the vector.
        '{CMD_INS, 16'h00ff,  2, 1'b0, 16'd0,    1'b0, ST_DONE,     11'd0, 16'sd0},
        '{CMD_QRY, 16'hfe00,  1, 1'b1, 16'd0,    1'b0, ST_DONE,     11'd0, 16'sd0},
        // Count is three again, so the new id repeats the one still stored.
        '{CMD_INS, 16'h0040,  1, 1'b1, 16'd0,    1'b1, ST_DONE,     11'd4, 16'sd0},
        '{CMD_DEL, 16'h0000,  1, 1'b1, 16'd4,    1'b1, ST_DONE,     11'd4, 16'sd0}
    };

    initial begin
        result_t want, none;
        int      pick, rand_start;
        none = '{status: ST_DONE, entry_id: '0, score: '0};
        entries = 0;
        comp_pos = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            want = '{status: plan[n].status, entry_id: plan[n].entry_id,
                     score: plan[n].score};
            for (int k = 0; k < plan[n].reps; k++)
                send(plan[n].cmd, plan[n].elem,
                     (k == plan[n].reps - 1) ? plan[n].last : 1'b0,
                     plan[n].target, plan[n].typed, want);
        end

        rand_start = items_sent;
        while (items_sent - rand_start < 150) begin
            pick = $urandom_range(0, 99);
            if (entries < 3 || (entries < 24 && pick < 40)) begin
                send_vector(CMD_INS, rand_len(), 1'b1);
            end else if (pick < 70) begin
                send_vector(CMD_QRY, rand_len(), 1'b1);
            end else if (pick < 85 || entries >= 24) begin
                send(CMD_DEL, rand_elem(3),
                     1'($urandom_range(0, 1)),
                     ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                 : 16'(id_mem[$urandom_range(0, entries-1)]),
                     1'b0, none);
            end else if (pick < 90) begin
                send(CMD_NOP, rand_elem(3), 1'($urandom_range(0, 1)), 16'($urandom),
                     1'b0, none);
            end else if (pick < 95) begin
                // Components of both kinds in one vector; the final one decides.
                send_vector($urandom_range(0, 1) ? CMD_INS : CMD_QRY, rand_len(), 1'b0);
                send(CMD_NOP, rand_elem(3), 1'b1, 16'($urandom), 1'b0, none);
                send_vector($urandom_range(0, 1) ? CMD_INS : CMD_QRY, rand_len(), 1'b1);
            end else begin
                send_vector(CMD_INS, rand_len(), 1'b0);
                send(CMD_DEL, 16'h0000, 1'b1, 16'($urandom_range(0, 40)), 1'b0, none);
            end
        end

        // Fill to capacity with no idling, then hit the full-table cases.
        bursts_on = 1'b0;
        while (entries < CAPACITY)
            send_vector(CMD_INS, 1, 1'b1);
        send_vector(CMD_INS, 3, 1'b0);
        send(CMD_INS, 16'h7fff, 1'b1, 16'd0, 1'b1,
             '{status: ST_FULL, entry_id: 11'd0, score: 16'sd0});
        send_vector(CMD_QRY, 4, 1'b1);
        send(CMD_DEL, 16'h0000, 1'b1, 16'(id_mem[CAPACITY-1]), 1'b0, none);
        send(CMD_DEL, 16'hffff, 1'b1, 16'hffff, 1'b1,
             '{status: ST_NOTFOUND, entry_id: 11'd0, score: 16'sd0});
        s_axis_tvalid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Sent %0d items; %0d results checked (%0d full, %0d empty, %0d not found).",
                 items_sent, checked, n_full, n_empty, n_miss);
        $display("Random inserts, queries and deletes with idle bursts, then a full table.");
        if (errors == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* cosine_nearest_vector_table.f */
rtl/cnvt_pkg.sv
rtl/cnvt_ram.sv
rtl/cnvt_score.sv
rtl/cnvt_front.sv
rtl/cnvt_back.sv
rtl/cosine_nearest_vector_table.sv
tb/sv/tb_cosine_nearest_vector_table.sv
